>>> rtl/core/key_value_record_parser_core_defines.svh
// Assertion helpers for the record parser core.
`ifndef KEY_VALUE_RECORD_PARSER_CORE_DEFINES_SVH
`define KEY_VALUE_RECORD_PARSER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define KVRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define KVRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/kvrp_pkg.sv
package kvrp_pkg;

    localparam int KEY_MAX_DEF   = 16;
    localparam int VALUE_MAX_DEF = 128;

    // Parser phase
    typedef enum logic [2:0] {
        PH_START,
        PH_KEY,
        PH_EQ,
        PH_VAL,
        PH_ERR
    } phase_t;

    // Number (uid) scanner phase
    typedef enum logic [1:0] {
        NUM_SPACE,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        num_phase_t  ph;
    } num_state_t;

    localparam num_state_t NUM_CLEAR = '{acc: 32'd0, neg: 1'b0, ph: NUM_SPACE};

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_KEY_START  = 3'd1;
    localparam logic [2:0] ERR_KEY_LONG   = 3'd2;
    localparam logic [2:0] ERR_KEY_CHAR   = 3'd3;
    localparam logic [2:0] ERR_VALUE_LONG = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd5;

    // Field ids
    localparam logic [1:0] FLD_EMAIL   = 2'd0;
    localparam logic [1:0] FLD_UID     = 2'd1;
    localparam logic [1:0] FLD_ROLE    = 2'd2;
    localparam logic [1:0] FLD_UNKNOWN = 2'd3;

    // Characters
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] email_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = 8'h65; // e
            3'd1:    c = 8'h6D; // m
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h69; // i
            3'd4:    c = 8'h6C; // l
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] uid_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = 8'h75; // u
            3'd1:    c = 8'h69; // i
            3'd2:    c = 8'h64; // d
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] role_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = 8'h72; // r
            3'd1:    c = 8'h6F; // o
            3'd2:    c = 8'h6C; // l
            3'd3:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Drop match flags of names that disagree with character c at position p.
    function automatic logic [2:0] key_flags(input logic [7:0] p, input logic [7:0] c,
                                             input logic [2:0] f);
        logic [2:0] r;
        r = f;
        if (p >= 8'd5 || email_char(p[2:0]) != c) r[0] = 1'b0;
        if (p >= 8'd3 || uid_char(p[2:0]) != c)   r[1] = 1'b0;
        if (p >= 8'd4 || role_char(p[2:0]) != c)  r[2] = 1'b0;
        return r;
    endfunction

    function automatic logic [1:0] key_id(input logic [2:0] f, input logic [7:0] len);
        logic [1:0] id;
        if (f[0] && len == 8'd5)      id = FLD_EMAIL;
        else if (f[1] && len == 8'd3) id = FLD_UID;
        else if (f[2] && len == 8'd4) id = FLD_ROLE;
        else                          id = FLD_UNKNOWN;
        return id;
    endfunction

endpackage

>>> rtl/core/kvrp_num.sv
// Saturating decimal scanner for the uid value: one character per request.
module kvrp_num (
    input  kvrp_pkg::num_state_t cur,
    input  logic                 en,
    input  logic [7:0]           ch,
    output kvrp_pkg::num_state_t nxt,
    output logic [31:0]          uid
);

    localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

    logic        go_digits;
    logic [35:0] prod;

    // acc * 10 + digit, clipped at 2^31
    assign prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                  + {32'd0, ch[3:0] - 4'd0};

    always_comb begin
        nxt       = cur;
        go_digits = 1'b0;
        if (en) begin
            // leading blanks and an optional sign
            if (cur.ph == kvrp_pkg::NUM_SPACE) begin
                if (kvrp_pkg::is_space(ch)) begin
                    go_digits = 1'b0;
                end else if (ch == kvrp_pkg::CH_PLUS || ch == kvrp_pkg::CH_MINUS) begin
                    nxt.neg = (ch == kvrp_pkg::CH_MINUS);
                    nxt.ph  = kvrp_pkg::NUM_DIGITS;
                end else begin
                    nxt.ph    = kvrp_pkg::NUM_DIGITS;
                    go_digits = 1'b1;
                end
            end else if (cur.ph == kvrp_pkg::NUM_DIGITS) begin
                go_digits = 1'b1;
            end
            // digit run
            if (go_digits) begin
                if (kvrp_pkg::is_digit(ch)) begin
                    nxt.acc = (prod > MAG_CAP) ? MAG_CAP[31:0] : prod[31:0];
                end else begin
                    nxt.ph = kvrp_pkg::NUM_DONE;
                end
            end
        end
    end

    // signed result; magnitude is at most 2^31
    assign uid = nxt.neg ? (32'd0 - nxt.acc) : (nxt.acc[31] ? 32'h7FFF_FFFF : nxt.acc);

endmodule

>>> rtl/core/key_value_record_parser_core.sv
// Key/value record parser: takes one record byte per request on the s_ side and gives exactly
// one result per byte on the m_ side, one byte per clock sustained while m_tready stays high.
// Each byte passes through a single registered step: the parse state and the result register
// are both updated at the edge that accepts it, so the next byte can enter on the following
// cycle; the result register lets a new byte in whenever it is empty or being taken. m_tvalid
// is registered. Keys (email, uid, role) are matched character by character as they arrive.
`include "key_value_record_parser_core_defines.svh"

module key_value_record_parser_core #(
    parameter int KEY_MAX   = kvrp_pkg::KEY_MAX_DEF,
    parameter int VALUE_MAX = kvrp_pkg::VALUE_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] value_valid, [8:1] value_byte, [9] field_done,
                                   // [41:10] uid_value, [44:42] error_code, zero above
    output logic [1:0]  m_tuser,   // [1:0] field_id
    output logic        m_tlast    // record_end
);

    localparam int KLW = $clog2(KEY_MAX + 1);
    localparam int VLW = $clog2(VALUE_MAX + 1);

    // parse state
    kvrp_pkg::phase_t     phase_reg, phase_next, phase_mid;
    logic [KLW-1:0]       klen_reg, klen_next;
    logic [2:0]           kflags_reg, kflags_next;
    logic [VLW-1:0]       vlen_reg, vlen_next;
    kvrp_pkg::num_state_t num_reg, num_next, num_cur, num_upd;

    // result register
    logic        m_tvalid_reg;
    logic        vvalid_reg, vvalid_next;
    logic [7:0]  vbyte_reg, vbyte_next;
    logic [1:0]  fid_reg, fid_next;
    logic        fdone_reg, fdone_next;
    logic [31:0] uid_reg, uid_next;
    logic [2:0]  err_reg, err_next;
    logic        rend_reg;

    logic        s_accept;
    logic        store, completed, do_clear, complete_now;
    logic [1:0]  id;
    logic [31:0] uid_w;
    logic [7:0]  b;

    assign b        = s_tdata;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    kvrp_num u_num (
        .cur (num_cur),
        .en  (store),
        .ch  (b),
        .nxt (num_upd),
        .uid (uid_w)
    );

    assign num_cur = do_clear ? kvrp_pkg::NUM_CLEAR : num_reg;

    // per-byte step
    always_comb begin
        phase_mid   = phase_reg;
        klen_next   = klen_reg;
        kflags_next = kflags_reg;
        vlen_next   = vlen_reg;
        store       = 1'b0;
        completed   = 1'b0;
        do_clear    = 1'b0;
        err_next    = kvrp_pkg::ERR_NONE;

        case (phase_reg)
            kvrp_pkg::PH_START: begin
                if (kvrp_pkg::is_alpha(b) || b == kvrp_pkg::CH_UNDER) begin
                    do_clear    = 1'b1;
                    vlen_next   = '0;
                    kflags_next = kvrp_pkg::key_flags(8'd0, b, 3'b111);
                    klen_next   = KLW'(1);
                    phase_mid   = kvrp_pkg::PH_KEY;
                end else begin
                    err_next  = kvrp_pkg::ERR_KEY_START;
                    phase_mid = kvrp_pkg::PH_ERR;
                end
            end
            kvrp_pkg::PH_KEY: begin
                if (kvrp_pkg::is_alpha(b) || kvrp_pkg::is_digit(b) || b == kvrp_pkg::CH_UNDER) begin
                    if (32'(klen_reg) >= KEY_MAX) begin
                        err_next  = kvrp_pkg::ERR_KEY_LONG;
                        phase_mid = kvrp_pkg::PH_ERR;
                    end else begin
                        kflags_next = kvrp_pkg::key_flags(8'(klen_reg), b, kflags_reg);
                        klen_next   = klen_reg + KLW'(1);
                    end
                end else if (b == kvrp_pkg::CH_EQ) begin
                    phase_mid = kvrp_pkg::PH_EQ;
                end else begin
                    err_next  = kvrp_pkg::ERR_KEY_CHAR;
                    phase_mid = kvrp_pkg::PH_ERR;
                end
            end
            kvrp_pkg::PH_EQ: begin
                if (b != kvrp_pkg::CH_EQ && b != kvrp_pkg::CH_AMP) begin
                    store     = 1'b1;
                    phase_mid = kvrp_pkg::PH_VAL;
                end
            end
            kvrp_pkg::PH_VAL: begin
                if (32'(vlen_reg) >= VALUE_MAX) begin
                    err_next  = kvrp_pkg::ERR_VALUE_LONG;
                    phase_mid = kvrp_pkg::PH_ERR;
                end else if (b == kvrp_pkg::CH_AMP) begin
                    completed = 1'b1;
                end else if (b != kvrp_pkg::CH_EQ) begin
                    store = 1'b1;
                end
            end
            default: ;
        endcase

        if (store) vlen_next = vlen_reg + VLW'(1);
        num_next = num_upd;

        id       = kvrp_pkg::key_id(kflags_next, 8'(klen_next));
        fid_next = (phase_mid == kvrp_pkg::PH_KEY || phase_mid == kvrp_pkg::PH_EQ ||
                    phase_mid == kvrp_pkg::PH_VAL) ? id : kvrp_pkg::FLD_UNKNOWN;

        // field completion at '&' or at the record's last byte while in a value
        complete_now = completed || (s_tlast && phase_mid == kvrp_pkg::PH_VAL);
        phase_next   = phase_mid;
        fdone_next   = 1'b0;
        uid_next     = 32'd0;
        if (complete_now) begin
            if (id == kvrp_pkg::FLD_UNKNOWN) begin
                err_next   = kvrp_pkg::ERR_UNKNOWN;
                phase_next = kvrp_pkg::PH_ERR;
            end else begin
                fdone_next  = 1'b1;
                uid_next    = (id == kvrp_pkg::FLD_UID) ? uid_w : 32'd0;
                phase_next  = kvrp_pkg::PH_START;
                klen_next   = '0;
                kflags_next = 3'b111;
                vlen_next   = '0;
                num_next    = kvrp_pkg::NUM_CLEAR;
            end
        end

        // record end: back to the reset state
        if (s_tlast) begin
            phase_next  = kvrp_pkg::PH_START;
            klen_next   = '0;
            kflags_next = 3'b111;
            vlen_next   = '0;
            num_next    = kvrp_pkg::NUM_CLEAR;
        end

        vvalid_next = store;
        vbyte_next  = store ? b : 8'd0;
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= kvrp_pkg::PH_START;
            klen_reg     <= '0;
            kflags_reg   <= 3'b111;
            vlen_reg     <= '0;
            num_reg      <= kvrp_pkg::NUM_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg  <= phase_next;
                klen_reg   <= klen_next;
                kflags_reg <= kflags_next;
                vlen_reg   <= vlen_next;
                num_reg    <= num_next;
            end
            if (s_accept)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            vvalid_reg <= vvalid_next;
            vbyte_reg  <= vbyte_next;
            fid_reg    <= fid_next;
            fdone_reg  <= fdone_next;
            uid_reg    <= uid_next;
            err_reg    <= err_next;
            rend_reg   <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, err_reg, uid_reg, fdone_reg, vbyte_reg, vvalid_reg};
    assign m_tuser  = fid_reg;
    assign m_tlast  = rend_reg;

    // checks
    `KVRP_ASSERT(a_end_resets, (s_accept && s_tlast) |=> (phase_reg == kvrp_pkg::PH_START && klen_reg == '0 && vlen_reg == '0), "record end did not return parser to start")
    `KVRP_ASSERT(a_done_no_err, (m_tvalid && fdone_reg) |-> (err_reg == kvrp_pkg::ERR_NONE && fid_reg != kvrp_pkg::FLD_UNKNOWN), "field done with error or unknown field")
    `KVRP_ASSERT(a_uid_only_done, (m_tvalid && uid_reg != 32'd0) |-> (fdone_reg && fid_reg == kvrp_pkg::FLD_UID), "uid value outside uid completion")
    `KVRP_ASSERT_ALWAYS(a_no_ready_rst, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

>>> tb/tb_top.sv
module tb_top;
    import kvrp_pkg::*;

    // One result as the parser reports it, unpacked from m_tdata / m_tuser / m_tlast
    typedef struct packed {
        logic        value_valid;
        logic [7:0]  value_byte;
        logic [1:0]  field_id;
        logic        field_done;
        logic [31:0] uid_value;
        logic [2:0]  error_code;
        logic        record_end;
    } field_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } rec_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;   // in_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [0] value_valid, [8:1] value_byte, [9] field_done,
                                    // [41:10] uid_value, [44:42] error_code, zero above
    logic [1:0]  m_tuser;           // [1:0] field_id
    logic        m_tlast;           // record_end

    key_value_record_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Record bytes waiting to go out, and parser results still owed by the block
    rec_byte_t     byte_q[$];
    logic [7:0]    rec_bytes[$];
    field_result_t field_results_due[$];

    int fail_n     = 0;
    int n_sent     = 0;
    int drain_mark = -1;

    string near_keys[6]   = '{"emai", "uidx", "Role", "rolee", "_uid", "emails"};
    string big_numbers[6] = '{"2147483647", "2147483648", "2147483649",
                              "4294967296", "99999999999", "0"};
    string mark_runs[3]   = '{"=", "&", "=&="};

    //------------------------------------------------------------------
    // Parser prediction
    //------------------------------------------------------------------
    phase_t       ps_phase;
    logic [4:0]   ps_key_len;
    logic [127:0] ps_key_text;   // key characters, newest in the low byte
    logic [7:0]   ps_val_len;
    logic [31:0]  ps_acc;
    logic         ps_neg;
    num_phase_t   ps_num;

    function automatic logic letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_ch(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void clear_field_state();
        ps_key_len  = '0;
        ps_key_text = '0;
        ps_val_len  = '0;
        ps_acc      = '0;
        ps_neg      = 1'b0;
        ps_num      = NUM_SPACE;
    endfunction

    function automatic void reset_parser();
        ps_phase = PH_START;
        clear_field_state();
    endfunction

    function automatic void take_key_char(input logic [7:0] c);
        ps_key_text = {ps_key_text[119:0], c};
        ps_key_len  = ps_key_len + 5'd1;
    endfunction

    // Exact match of the held key against the three known names
    function automatic logic [1:0] held_field();
        if (ps_key_len == 5'd5 && ps_key_text[39:0] == "email") return FLD_EMAIL;
        if (ps_key_len == 5'd3 && ps_key_text[23:0] == "uid") return FLD_UID;
        if (ps_key_len == 5'd4 && ps_key_text[31:0] == "role") return FLD_ROLE;
        return FLD_UNKNOWN;
    endfunction

    // Saturating atoi: blanks, one sign, then digits until the first non-digit
    function automatic void feed_number(input logic [7:0] c);
        logic        sign_now;
        logic [63:0] t;
        sign_now = 1'b0;
        if (ps_num == NUM_SPACE && !blank_ch(c)) begin
            ps_num = NUM_DIGITS;
            if (c == CH_PLUS || c == CH_MINUS) begin
                ps_neg   = (c == CH_MINUS);
                sign_now = 1'b1;
            end
        end
        if (ps_num == NUM_DIGITS && !sign_now) begin
            if (digit_ch(c)) begin
                t      = {32'd0, ps_acc} * 64'd10 + {56'd0, c - 8'h30};
                ps_acc = (t > 64'h8000_0000) ? 32'h8000_0000 : t[31:0];
            end else begin
                ps_num = NUM_DONE;
            end
        end
    endfunction

    function automatic void take_value_char(input logic [7:0] c, inout field_result_t r);
        ps_val_len = ps_val_len + 8'd1;
        feed_number(c);
        r.value_valid = 1'b1;
        r.value_byte  = c;
    endfunction

    function automatic void close_field(inout field_result_t r);
        logic [1:0] id;
        id = held_field();
        if (id == FLD_UNKNOWN) begin
            r.field_id   = FLD_UNKNOWN;
            r.error_code = ERR_UNKNOWN;
            ps_phase     = PH_ERR;
        end else begin
            r.field_id   = id;
            r.field_done = 1'b1;
            if (id == FLD_UID) begin
                if (ps_neg)
                    r.uid_value = 32'd0 - ps_acc;
                else
                    r.uid_value = (ps_acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : ps_acc;
            end
            clear_field_state();
            ps_phase = PH_START;
        end
    endfunction

    // Advance the parser by one record byte and give the result it causes
    function automatic field_result_t parse_step(input logic [7:0] c, input logic l);
        field_result_t r;
        logic          closed;
        r          = '0;
        r.field_id = FLD_UNKNOWN;
        closed     = 1'b0;
        case (ps_phase)
            PH_START: begin
                if (letter_ch(c) || c == CH_UNDER) begin
                    clear_field_state();
                    take_key_char(c);
                    ps_phase = PH_KEY;
                end else begin
                    r.error_code = ERR_KEY_START;
                    ps_phase     = PH_ERR;
                end
            end
            PH_KEY: begin
                if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
                    if (ps_key_len >= KEY_MAX_DEF) begin
                        r.error_code = ERR_KEY_LONG;
                        ps_phase     = PH_ERR;
                    end else begin
                        take_key_char(c);
                    end
                end else if (c == CH_EQ) begin
                    ps_phase = PH_EQ;
                end else begin
                    r.error_code = ERR_KEY_CHAR;
                    ps_phase     = PH_ERR;
                end
            end
            PH_EQ: begin
                // leading marks are skipped
                if (c != CH_EQ && c != CH_AMP) begin
                    take_value_char(c, r);
                    ps_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                if (ps_val_len >= VALUE_MAX_DEF) begin
                    r.error_code = ERR_VALUE_LONG;
                    ps_phase     = PH_ERR;
                end else if (c == CH_AMP) begin
                    close_field(r);
                    closed = 1'b1;
                end else if (c != CH_EQ) begin
                    take_value_char(c, r);
                end
            end
            default: ;
        endcase
        if (!closed && ps_phase inside {PH_KEY, PH_EQ, PH_VAL})
            r.field_id = held_field();
        if (l) begin
            if (ps_phase == PH_VAL)
                close_field(r);
            r.record_end = 1'b1;
            reset_parser();
        end
        return r;
    endfunction

    //------------------------------------------------------------------
    // Record generation
    //------------------------------------------------------------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rec_bytes.push_back(s[i]);
    endtask

    task automatic flush_record();
        foreach (rec_bytes[i])
            byte_q.push_back('{ch: rec_bytes[i], last: (i == rec_bytes.size() - 1)});
        rec_bytes.delete();
    endtask

    function automatic logic [7:0] key_char(input logic first);
        int k;
        k = $urandom_range(0, first ? 52 : 62);
        if (k < 26) return 8'("a" + k);
        if (k < 52) return 8'("A" + k - 26);
        if (k == 52) return CH_UNDER;
        return 8'("0" + k - 53);
    endfunction

    // Value bytes: never '&', sometimes '=', mostly printable
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        int         k;
        k = $urandom_range(0, 9);
        do begin
            if (k < 6)
                c = 8'($urandom_range(32, 126));
            else if (k == 6)
                c = CH_EQ;
            else
                c = 8'($urandom_range(1, 255));
        end while (c == CH_AMP);
        return c;
    endfunction

    task automatic add_key(output logic is_uid);
        int k;
        int n;
        is_uid = 1'b0;
        k      = $urandom_range(0, 19);
        if (k < 5) begin
            add_text("email");
        end else if (k < 10) begin
            add_text("uid");
            is_uid = 1'b1;
        end else if (k < 14) begin
            add_text("role");
        end else if (k < 16) begin
            add_text(near_keys[$urandom_range(0, 5)]);
        end else if (k < 19) begin
            // random identifiers, around the key length limit now and then
            n = (k == 18) ? $urandom_range(15, 17) : $urandom_range(1, 6);
            rec_bytes.push_back(key_char(1'b1));
            for (int i = 1; i < n; i++)
                rec_bytes.push_back(key_char(1'b0));
        end else if ($urandom_range(0, 1)) begin
            rec_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            add_text("ro");
            rec_bytes.push_back(8'($urandom_range(1, 255)));
            add_text("le");
        end
    endtask

    task automatic add_number();
        int k;
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(8, 13);
            rec_bytes.push_back(k == 8 ? CH_SPACE : 8'(k));
        end
        k = $urandom_range(0, 2);
        if (k == 1) rec_bytes.push_back(CH_PLUS);
        if (k == 2) rec_bytes.push_back(CH_MINUS);
        case ($urandom_range(0, 5))
            0, 1:    add_text($sformatf("%0d", $urandom_range(0, 99999)));
            2:       add_text($sformatf("%0d", $urandom()));
            3:       add_text(big_numbers[$urandom_range(0, 5)]);
            4:       add_text($sformatf("%0d%0d", $urandom(), $urandom()));
            default: ;  // sign or blank alone
        endcase
        if ($urandom_range(0, 3) == 0)
            rec_bytes.push_back(value_char());
    endtask

    task automatic add_value(input logic is_uid);
        int n;
        if ($urandom_range(0, 4) == 0)
            add_text(mark_runs[$urandom_range(0, 2)]);
        if ($urandom_range(0, 59) == 0) begin
            n = $urandom_range(126, 131);
        end else if (is_uid && $urandom_range(0, 3) != 0) begin
            add_number();
            n = 0;
        end else begin
            n = $urandom_range(0, 10);
        end
        repeat (n) rec_bytes.push_back(value_char());
    endtask

    // Mostly well-formed records with random content, some plain noise
    task automatic gen_record();
        int   nf;
        logic is_uid;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) rec_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf; f++) begin
                if (f > 0) rec_bytes.push_back(CH_AMP);
                add_key(is_uid);
                if ($urandom_range(0, 19) != 0) rec_bytes.push_back(CH_EQ);
                add_value(is_uid);
            end
            if ($urandom_range(0, 7) == 0) rec_bytes.push_back(CH_AMP);
        end
        flush_record();
    endtask

    //------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps, two drain points
    //------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : drv
        logic      load;
        rec_byte_t nxt;
        load = 1'b0;
        nxt  = '0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                field_results_due.push_back(parse_step(s_tdata, s_tlast));
                n_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_q.size() != 0 &&
                             !((n_sent == drain_mark || n_sent == 700) &&
                               field_results_due.size() != 0)) begin
                    load = 1'b1;
                    nxt  = byte_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = 1;
                            2:       gap_left = $urandom_range(2, 6);
                            default: gap_left = $urandom_range(0, 15);
                        endcase
                    end
                end
                s_tvalid <= load;
                if (load) begin
                    s_tdata <= nxt.ch;
                    s_tlast <= nxt.last;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    //------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            fail_n++;
        end
    endtask

    int cycle_n    = 0;
    int stall_mode = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(posedge aclk) begin : mon
        field_result_t want;
        logic          rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (field_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h/%h/%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_n++;
                end else begin
                    want = field_results_due.pop_front();
                    check_field("value_valid", 32'(want.value_valid), 32'(m_tdata[0]));
                    check_field("value_byte", 32'(want.value_byte), 32'(m_tdata[8:1]));
                    check_field("field_done", 32'(want.field_done), 32'(m_tdata[9]));
                    check_field("uid_value", want.uid_value, m_tdata[41:10]);
                    check_field("error_code", 32'(want.error_code), 32'(m_tdata[44:42]));
                    check_field("tdata pad", 32'd0, 32'(m_tdata[47:45]));
                    check_field("field_id", 32'(want.field_id), 32'(m_tuser));
                    check_field("record_end", 32'(want.record_end), 32'(m_tlast));
                end
            end
            // long hold-offs so the result register fills and s_tready drops
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if ((holds_done == 0 && n_sent >= 400) ||
                         (holds_done == 1 && n_sent >= 1000)) begin
                holds_done++;
                hold_left = 250;
                rdy       = 1'b0;
            end else begin
                if (cycle_n % 128 == 0) stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = (cycle_n % 7 < 3);
                endcase
            end
            cycle_n++;
            m_tready <= rdy;
        end
    end

    //------------------------------------------------------------------
    // Stimulus, reset and end of run
    //------------------------------------------------------------------
    initial begin
        reset_parser();

        // repeated '=' after the key, signed uid, unknown key closed by the last byte
        add_text("uid==-12&ROLE=x");
        flush_record();
        // bad key start
        add_text("9");
        flush_record();
        // bad key character, then a byte ignored after the error
        add_text("r-x");
        flush_record();
        // record ending inside a key: no field, no error
        add_text("uid");
        flush_record();
        // top byte value closed by the last byte
        add_text("role=");
        rec_bytes.push_back(8'hFF);
        flush_record();
        drain_mark = byte_q.size();

        while (byte_q.size() < 1330)
            gen_record();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_q.size() != 0 || s_tvalid || field_results_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_n == 0 && field_results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
